>>> design/mrc_pkg.sv
// Shared types, status codes and the CRC16 step for the Modbus RTU reply checker.
`timescale 1ns / 1ps

package mrc_pkg;

	// Frame status codes reported with a status beat.
	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_EMPTY      = 4'd1,
		ST_SHORT      = 4'd2,
		ST_EXCEPTION  = 4'd3,
		ST_BAD_SLAVE  = 4'd4,
		ST_BAD_FUNC   = 4'd5,
		ST_BAD_COUNT  = 4'd6,
		ST_INCOMPLETE = 4'd7,
		ST_CRC        = 4'd8
	} status_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
	localparam logic [1:0] REG_FUNC_CODE  = 2'd1;
	localparam logic [1:0] REG_REG_COUNT  = 2'd2;
	localparam logic [1:0] REG_CHECK_MODE = 2'd3;

	// Output beat kinds carried on tuser.
	localparam logic KIND_WORD   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Input beat kinds carried on tuser.
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_EOF  = 1'b1;

	localparam logic MODE_READ = 1'b0;
	localparam logic MODE_ECHO = 1'b1;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] slave_addr;
		logic [7:0] func_code;
		logic [6:0] reg_count;
		logic       check_mode;
	} cfg_t;

	// One received byte folded into a reflected CRC16.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> design/mrc_queue.sv
// Short first-in first-out queue between the front and back parts of the checker.
`timescale 1ns / 1ps

module mrc_queue #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNTW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/mrc_front.sv
// Front part: accepts input beats, tracks the byte position and drops overlong bytes.
`timescale 1ns / 1ps

module mrc_front #(
	parameter int MAX_FRAME = 256,
	parameter int PW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          in_func,
	input  logic [7:0]    in_byte,
	input  logic          q_full,
	output logic          q_push,
	output logic [PW+8:0] q_item
);

	logic [PW-1:0] pos_q;
	logic          accept;
	logic          in_range;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign in_range = (pos_q < PW'(MAX_FRAME));

	// An end-of-frame beat carries the byte count; a data byte carries its position.
	assign q_push = accept && ((in_func == mrc_pkg::FUNC_EOF) || in_range);
	assign q_item = {pos_q, in_byte, in_func};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (in_func == mrc_pkg::FUNC_EOF) begin
				pos_q <= '0;
			end else if (in_range) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

>>> design/mrc_back.sv
// Back part: runs the CRC, captures header fields, emits words and the frame status.
`timescale 1ns / 1ps

module mrc_back #(
	parameter int PW = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mrc_pkg::cfg_t        cfg,
	input  logic                 q_valid,
	input  logic [PW+8:0]        q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_kind,
	output logic [6:0]           out_reg_index,
	output logic [15:0]          out_reg_value,
	output logic [3:0]           out_status,
	output logic [7:0]           out_exception_code
);

	localparam int CW = (PW > 9) ? PW : 9;

	logic          item_eof;
	logic [7:0]    item_byte;
	logic [CW-1:0] pos;

	logic [15:0] crc_q;
	logic [7:0]  addr_q;
	logic [7:0]  func_q;
	logic [7:0]  third_q;
	logic [15:0] crc_rx_q;
	logic [7:0]  hold_q;

	logic        out_valid_q;
	logic        out_kind_q;
	logic [6:0]  out_index_q;
	logic [15:0] out_value_q;
	logic [3:0]  out_status_q;
	logic [7:0]  out_exc_q;

	logic             take;
	logic [CW-1:0]    cov_len;
	logic [CW-1:0]    pos_minus4;
	logic [15:0]      crc_next;
	logic             crc_bad;
	logic             exc_flag;
	logic             word_done;
	mrc_pkg::status_t status;

	assign item_eof  = q_item[0];
	assign item_byte = q_item[8:1];
	assign pos       = CW'(q_item[PW+8:9]);

	assign take  = q_valid && (!out_valid_q || out_ready);
	assign q_pop = take;

	assign cov_len    = (cfg.check_mode == mrc_pkg::MODE_ECHO) ? CW'(6)
		: CW'(3) + CW'({cfg.reg_count, 1'b0});
	assign pos_minus4 = pos - CW'(4);
	assign crc_next   = mrc_pkg::crc16_byte(crc_q, item_byte);
	assign crc_bad    = (crc_rx_q != crc_q);
	assign exc_flag   = func_q[7];

	// A register word completes on every second byte of the data area in read mode.
	assign word_done = (cfg.check_mode == mrc_pkg::MODE_READ) && (pos < cov_len)
		&& (pos >= CW'(4)) && !pos[0];

	always_comb begin
		status = mrc_pkg::ST_OK;
		if (pos == '0) begin
			status = mrc_pkg::ST_EMPTY;
		end else if (cfg.check_mode == mrc_pkg::MODE_ECHO) begin
			if (pos >= CW'(5) && exc_flag) begin
				status = mrc_pkg::ST_EXCEPTION;
			end else if (pos < CW'(8)) begin
				status = mrc_pkg::ST_SHORT;
			end else if (crc_bad) begin
				status = mrc_pkg::ST_CRC;
			end else if (addr_q != cfg.slave_addr) begin
				status = mrc_pkg::ST_BAD_SLAVE;
			end else if (func_q != cfg.func_code) begin
				status = mrc_pkg::ST_BAD_FUNC;
			end
		end else begin
			if (pos < CW'(5)) begin
				status = mrc_pkg::ST_SHORT;
			end else if (exc_flag) begin
				status = mrc_pkg::ST_EXCEPTION;
			end else if (addr_q != cfg.slave_addr) begin
				status = mrc_pkg::ST_BAD_SLAVE;
			end else if (func_q != cfg.func_code) begin
				status = mrc_pkg::ST_BAD_FUNC;
			end else if (third_q != {cfg.reg_count, 1'b0}) begin
				status = mrc_pkg::ST_BAD_COUNT;
			end else if (pos < cov_len + CW'(2)) begin
				status = mrc_pkg::ST_INCOMPLETE;
			end else if (crc_bad) begin
				status = mrc_pkg::ST_CRC;
			end
		end
	end

	// Frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= mrc_pkg::CRC_INIT;
			addr_q   <= '0;
			func_q   <= '0;
			third_q  <= '0;
			crc_rx_q <= '0;
			hold_q   <= '0;
		end else if (take) begin
			if (item_eof) begin
				crc_q    <= mrc_pkg::CRC_INIT;
				addr_q   <= '0;
				func_q   <= '0;
				third_q  <= '0;
				crc_rx_q <= '0;
				hold_q   <= '0;
			end else begin
				if (pos == CW'(0)) begin
					addr_q <= item_byte;
				end
				if (pos == CW'(1)) begin
					func_q <= item_byte;
				end
				if (pos == CW'(2)) begin
					third_q <= item_byte;
				end
				if (pos < cov_len) begin
					crc_q <= crc_next;
					if (cfg.check_mode == mrc_pkg::MODE_READ && pos >= CW'(3) && pos[0]) begin
						hold_q <= item_byte;
					end
				end else if (pos == cov_len) begin
					crc_rx_q[7:0] <= item_byte;
				end else if (pos == cov_len + CW'(1)) begin
					crc_rx_q[15:8] <= item_byte;
				end
			end
		end
	end

	// Output register: holds a finished beat until the receiver takes it; no item is taken while it waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= item_eof || word_done;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (item_eof) begin
				out_kind_q   <= mrc_pkg::KIND_STATUS;
				out_index_q  <= '0;
				out_value_q  <= '0;
				out_status_q <= status;
				out_exc_q    <= (status == mrc_pkg::ST_EXCEPTION) ? third_q : 8'h00;
			end else begin
				out_kind_q   <= mrc_pkg::KIND_WORD;
				out_index_q  <= pos_minus4[7:1];
				out_value_q  <= {hold_q, item_byte};
				out_status_q <= mrc_pkg::ST_OK;
				out_exc_q    <= '0;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign out_kind           = out_kind_q;
	assign out_reg_index      = out_index_q;
	assign out_reg_value      = out_value_q;
	assign out_status         = out_status_q;
	assign out_exception_code = out_exc_q;

endmodule

>>> design/modbus_rtu_response_checker.sv
// Top level of the Modbus RTU reply checker: configuration registers, front, queue and back.
`timescale 1ns / 1ps

// The checker watches a Modbus RTU slave reply one received byte per input beat.
// Input stream: tuser says whether the beat is a data byte (0) or the end of the
// frame (1, bus silence); tdata carries the byte. Output stream: tuser 0 marks a
// tentative register word in read mode, tuser 1 marks the one status beat that
// closes each frame. Words belong to the frame and should be kept only if that
// frame's status is ok. Bytes past MAX_FRAME in a frame are dropped by the front.
// The configuration port writes slave address, function code, register count
// and check mode; it is to be written only while no frame is in flight, and the
// block does not enforce this. An accepted input beat passes through the queue
// and the output register before its result reaches the output.
// Throughput is one beat per cycle while the receiver keeps up: the front takes a
// beat every cycle unless the queue is full, and the back folds one byte into the
// CRC per cycle but stops while a result waits. When the receiver stalls, up to four
// beats collect in the queue between front and back; s_axis_tready falls once it is full.
// Reset clears the byte position, the CRC to 0xFFFF, the captured header fields,
// empties the queue and output register, and loads the register reset values
// (slave 1, function 3, one register, read mode).
module modbus_rtu_response_checker #(
	parameter int MAX_FRAME = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input beat.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tuser,   // [0] func
	// Result beat.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [6:0] reg_index, [22:7] reg_value,
	                                    // [26:23] status, [34:27] exception_code, rest zero
	output logic        m_axis_tuser,   // [0] kind
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata
);

	// The position counter must reach MAX_FRAME itself, as the byte count of a full frame.
	localparam int PW = $clog2(MAX_FRAME + 1);
	localparam int QW = PW + 9;

	mrc_pkg::cfg_t cfg_q;

	logic          q_push;
	logic [QW-1:0] q_push_item;
	logic          q_full;
	logic          q_pop;
	logic          q_not_empty;
	logic [QW-1:0] q_pop_item;

	logic [6:0]  reg_index;
	logic [15:0] reg_value;
	logic [3:0]  status;
	logic [7:0]  exception_code;

	// Configuration registers; each write lands at once with no handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_addr <= 8'd1;
			cfg_q.func_code  <= 8'd3;
			cfg_q.reg_count  <= 7'd1;
			cfg_q.check_mode <= mrc_pkg::MODE_READ;
		end else if (cfg_we) begin
			case (cfg_addr)
				mrc_pkg::REG_SLAVE_ADDR: cfg_q.slave_addr <= cfg_wdata;
				mrc_pkg::REG_FUNC_CODE:  cfg_q.func_code  <= cfg_wdata;
				mrc_pkg::REG_REG_COUNT:  cfg_q.reg_count  <= cfg_wdata[6:0];
				mrc_pkg::REG_CHECK_MODE: cfg_q.check_mode <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	mrc_front #(
		.MAX_FRAME (MAX_FRAME),
		.PW        (PW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_func  (s_axis_tuser),
		.in_byte  (s_axis_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_push_item)
	);

	mrc_queue #(
		.WIDTH (QW),
		.DEPTH (mrc_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_pop_item)
	);

	mrc_back #(
		.PW (PW)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.q_valid            (q_not_empty),
		.q_item             (q_pop_item),
		.q_pop              (q_pop),
		.out_valid          (m_axis_tvalid),
		.out_ready          (m_axis_tready),
		.out_kind           (m_axis_tuser),
		.out_reg_index      (reg_index),
		.out_reg_value      (reg_value),
		.out_status         (status),
		.out_exception_code (exception_code)
	);

	// Pack the result fields from the lowest bit up and pad to whole bytes.
	assign m_axis_tdata = {5'b0, exception_code, status, reg_value, reg_index};

endmodule

>>> design/mrc_checker.sv
// Port-level assertions for the Modbus RTU reply checker, bound to the top level.
`timescale 1ns / 1ps

module mrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// A stalled result beat keeps its payload until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// A register word never carries status or exception bits.
	a_word_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == mrc_pkg::KIND_WORD) |->
			(m_axis_tdata[39:23] == '0))
		else $error("register word carries status fields");

	// A status beat has no word fields and a defined status code.
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == mrc_pkg::KIND_STATUS) |->
			(m_axis_tdata[22:0] == '0) && (m_axis_tdata[26:23] <= mrc_pkg::ST_CRC)
			&& (m_axis_tdata[39:35] == '0))
		else $error("status beat malformed");

	// The exception code is only reported with an exception status.
	a_exc_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == mrc_pkg::KIND_STATUS)
			&& (m_axis_tdata[26:23] != mrc_pkg::ST_EXCEPTION) |->
			(m_axis_tdata[34:27] == 8'h00))
		else $error("exception code without exception status");

endmodule

bind modbus_rtu_response_checker mrc_checker u_mrc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
